// ===== rtl/core/srmv_pkg.sv =====
// Shared types and constants for the sparse row matrix-vector multiply core.
// Used by the front end, the queue, the back end and the top level.
package srmv_pkg;

    // Vector store geometry: the column field addresses every entry.
    localparam int VEC_DEPTH = 4096;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 16;
    localparam int NUM_W     = 32;
    localparam int ACC_W     = 64;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Action codes of an input word.
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_NONZERO = 1'b1;

    // Rounding and saturation limits for the Q32.32 to Q16.16 conversion.
    localparam logic signed [ACC_W-1:0] SUM_HI_LIM  = 64'sh0000_7FFF_FFFF_8000;
    localparam logic signed [ACC_W-1:0] SUM_LO_LIM  = 64'shFFFF_7FFF_FFFF_8000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = 64'sh0000_0000_0000_8000;
    localparam logic signed [ACC_W-1:0] ACC_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN     = 64'sh8000_0000_0000_0000;
    localparam logic signed [NUM_W-1:0] SUM_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [NUM_W-1:0] SUM_MIN     = 32'sh8000_0000;

    // One classified nonzero word handed from the front to the back.
    typedef struct packed {
        logic signed [NUM_W-1:0] number;
        logic signed [NUM_W-1:0] elem;
        logic [ROW_W-1:0]        row;
        logic                    row_end;
    } t_nz_word;

    // Push request from the front into the queue.
    typedef struct packed {
        logic     valid;
        t_nz_word word;
    } t_push;

endpackage

// ===== rtl/core/sparse_row_matrix_vector_multiply_core.sv =====
// Top level of the sparse row matrix-vector multiply core.
// Uses srmv_pkg, srmv_front, srmv_queue and srmv_back.

// The core takes one input word per clock, loads and nonzeros alike, as long
// as the result side keeps up. A load writes one Q16.16 vector element into a
// 4096-entry vector store; a nonzero reads the element at its column, and the
// product joins the running row sum. The nonzero marked as the end of its row
// produces one result word, the sum rounded to Q16.16 with saturation, which
// is offered on the result side after the fetch stage, the queue, the product
// stage, the finished-sum stage and the output register. A load may be
// followed by a nonzero that uses it in the very next cycle. A four-entry
// queue separates the fetch front end from the multiply-accumulate back end;
// the input stalls only when the queued words and the word in the fetch stage
// together fill those four entries, which happens when the result side holds
// off. Vector elements that were never loaded read as undefined values.
module sparse_row_matrix_vector_multiply_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [srmv_pkg::COL_W-1:0]        i_column,
    input  logic [srmv_pkg::ROW_W-1:0]        i_row,
    input  logic signed [srmv_pkg::NUM_W-1:0] i_number,
    input  logic                              i_row_end,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [srmv_pkg::ROW_W-1:0]        o_out_row,
    output logic signed [srmv_pkg::NUM_W-1:0] o_row_sum,
    output logic                              o_clipped
);

    srmv_pkg::t_push                 push;
    srmv_pkg::t_nz_word              q_word;
    logic                            q_valid;
    logic                            q_pop;
    logic [srmv_pkg::QCNT_W-1:0]     q_level;

    // Front end: vector store and element fetch.
    srmv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_column (i_column),
        .i_row    (i_row),
        .i_number (i_number),
        .i_row_end(i_row_end),
        .i_q_level(q_level),
        .o_push   (push)
    );

    // Queue between the two halves.
    srmv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_word (q_word),
        .o_level(q_level)
    );

    // Back end: multiply, accumulate, round.
    srmv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_word (q_word),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out_row(o_out_row),
        .o_row_sum(o_row_sum),
        .o_clipped(o_clipped)
    );

    // The queue never fills past its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= srmv_pkg::QCNT_W'(srmv_pkg::QDEPTH))
        else $error("queue level above depth");

    // The front never pushes into a full queue that is not draining.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid && (q_level == srmv_pkg::QCNT_W'(srmv_pkg::QDEPTH)) |-> q_pop)
        else $error("push into a full queue");

    // An accepted nonzero word is pushed into the queue in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == srmv_pkg::ACT_NONZERO) |=> push.valid)
        else $error("nonzero word lost in fetch");

    // An accepted load word never reaches the queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == srmv_pkg::ACT_LOAD) |=> !push.valid)
        else $error("load word pushed into queue");

endmodule

// ===== rtl/core/srmv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/srmv_front.sv =====
// Front end: accepts input words, writes loads into the vector store and
// fetches the vector element for each nonzero. Uses srmv_pkg and srmv_ram.
module srmv_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_action,
    input  logic [srmv_pkg::COL_W-1:0]       i_column,
    input  logic [srmv_pkg::ROW_W-1:0]       i_row,
    input  logic signed [srmv_pkg::NUM_W-1:0] i_number,
    input  logic                             i_row_end,
    input  logic [srmv_pkg::QCNT_W-1:0]      i_q_level,
    output srmv_pkg::t_push                  o_push
);

    logic                             accept;
    logic                             ld_we;
    logic                             nz_re;
    logic [srmv_pkg::QCNT_W:0]        committed;
    logic [srmv_pkg::NUM_W-1:0]       ram_rdata;
    logic                             r_rd_valid;
    logic signed [srmv_pkg::NUM_W-1:0] r_number;
    logic [srmv_pkg::ROW_W-1:0]       r_row;
    logic                             r_row_end;

    // Take a word only when the queue has room for it and the one in flight.
    assign committed = {1'b0, i_q_level} + {{srmv_pkg::QCNT_W{1'b0}}, r_rd_valid};
    assign o_ready   = committed < (srmv_pkg::QCNT_W + 1)'(srmv_pkg::QDEPTH);
    assign accept    = i_valid && o_ready;
    assign ld_we     = accept && (i_action == srmv_pkg::ACT_LOAD);
    assign nz_re     = accept && (i_action == srmv_pkg::ACT_NONZERO);

    // Vector store.
    srmv_ram #(
        .WIDTH(srmv_pkg::NUM_W),
        .DEPTH(srmv_pkg::VEC_DEPTH)
    ) u_vec_store (
        .i_clk  (i_clk),
        .i_we   (ld_we),
        .i_waddr(i_column),
        .i_wdata(i_number),
        .i_re   (nz_re),
        .i_raddr(i_column),
        .o_rdata(ram_rdata)
    );

    // Fetch stage: hold the nonzero while its vector element is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= nz_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nz_re) begin
            r_number  <= i_number;
            r_row     <= i_row;
            r_row_end <= i_row_end;
        end
    end

    // Hand the classified nonzero to the queue.
    always_comb begin
        o_push.valid        = r_rd_valid;
        o_push.word.number  = r_number;
        o_push.word.elem    = ram_rdata;
        o_push.word.row     = r_row;
        o_push.word.row_end = r_row_end;
    end

endmodule

// ===== rtl/core/srmv_queue.sv =====
// Short queue of classified nonzero words between front and back.
// Uses srmv_pkg.
module srmv_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srmv_pkg::t_push             i_push,
    input  logic                        i_pop,
    output logic                        o_valid,
    output srmv_pkg::t_nz_word          o_word,
    output logic [srmv_pkg::QCNT_W-1:0] o_level
);

    srmv_pkg::t_nz_word              r_mem [srmv_pkg::QDEPTH];
    logic [srmv_pkg::QPTR_W-1:0]     r_wptr;
    logic [srmv_pkg::QPTR_W-1:0]     r_rptr;
    logic [srmv_pkg::QCNT_W-1:0]     r_count;
    logic [srmv_pkg::QCNT_W-1:0]     n_count;
    logic                            do_pop;

    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rptr];
    assign o_level = r_count;
    assign do_pop  = i_pop && o_valid;

    // Entry storage; the front never pushes into a full queue.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.word;
        end
    end

    // Pointers and fill count.
    always_comb begin
        n_count = r_count;
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/srmv_back.sv =====
// Back end: multiply, saturating row accumulate, then round and saturate to
// Q16.16 into the output register. Uses srmv_pkg.
module srmv_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  srmv_pkg::t_nz_word                i_q_word,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [srmv_pkg::ROW_W-1:0]        o_out_row,
    output logic signed [srmv_pkg::NUM_W-1:0] o_row_sum,
    output logic                              o_clipped
);

    // Product stage.
    logic                              r_p_valid;
    logic signed [srmv_pkg::ACC_W-1:0] r_p_prod;
    logic [srmv_pkg::ROW_W-1:0]        r_p_row;
    logic                              r_p_end;
    // Finished row sum stage.
    logic                              r_f_valid;
    logic signed [srmv_pkg::ACC_W-1:0] r_f_sum;
    logic [srmv_pkg::ROW_W-1:0]        r_f_row;
    // Row accumulator.
    logic signed [srmv_pkg::ACC_W-1:0] r_acc;
    // Output register.
    logic                              r_o_valid;
    logic [srmv_pkg::ROW_W-1:0]        r_o_row;
    logic signed [srmv_pkg::NUM_W-1:0] r_o_sum;
    logic                              r_o_clip;

    logic                              o_free;
    logic                              f_free;
    logic                              f_move;
    logic                              p_move;
    logic                              p_free;
    logic signed [srmv_pkg::ACC_W:0]   wide_sum;
    logic signed [srmv_pkg::ACC_W-1:0] sat_sum;
    logic signed [srmv_pkg::ACC_W-1:0] rounded;
    logic signed [srmv_pkg::NUM_W-1:0] n_o_sum;
    logic                              n_o_clip;

    // Stage flow control: a non-ending product never waits on the output side.
    assign o_free = !r_o_valid || i_ready;
    assign f_move = r_f_valid && o_free;
    assign f_free = !r_f_valid || o_free;
    assign p_move = r_p_valid && (!r_p_end || f_free);
    assign p_free = !r_p_valid || p_move;
    assign o_pop  = i_q_valid && p_free;

    // Multiply stage: exact Q32.32 product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_free) begin
            r_p_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_prod <= i_q_word.number * i_q_word.elem;
            r_p_row  <= i_q_word.row;
            r_p_end  <= i_q_word.row_end;
        end
    end

    // Saturating 64-bit accumulate.
    always_comb begin
        wide_sum = {r_acc[srmv_pkg::ACC_W-1], r_acc} + {r_p_prod[srmv_pkg::ACC_W-1], r_p_prod};
        if (wide_sum[srmv_pkg::ACC_W] != wide_sum[srmv_pkg::ACC_W-1]) begin
            sat_sum = wide_sum[srmv_pkg::ACC_W] ? srmv_pkg::ACC_MIN : srmv_pkg::ACC_MAX;
        end else begin
            sat_sum = wide_sum[srmv_pkg::ACC_W-1:0];
        end
    end

    // Accumulator and finished-sum stage; the row end clears the accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_f_valid <= 1'b0;
        end else begin
            if (p_move) begin
                r_acc <= r_p_end ? '0 : sat_sum;
            end
            if (p_move && r_p_end) begin
                r_f_valid <= 1'b1;
            end else if (f_move) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move && r_p_end) begin
            r_f_sum <= sat_sum;
            r_f_row <= r_p_row;
        end
    end

    // Round half up to Q16.16 and saturate.
    always_comb begin
        rounded = r_f_sum + srmv_pkg::ROUND_HALF;
        if (r_f_sum >= srmv_pkg::SUM_HI_LIM) begin
            n_o_sum  = srmv_pkg::SUM_MAX;
            n_o_clip = 1'b1;
        end else if (r_f_sum < srmv_pkg::SUM_LO_LIM) begin
            n_o_sum  = srmv_pkg::SUM_MIN;
            n_o_clip = 1'b1;
        end else begin
            n_o_sum  = rounded[47:16];
            n_o_clip = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (f_move) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_move) begin
            r_o_row  <= r_f_row;
            r_o_sum  <= n_o_sum;
            r_o_clip <= n_o_clip;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_out_row = r_o_row;
    assign o_row_sum = r_o_sum;
    assign o_clipped = r_o_clip;

endmodule
